>>> rtl/fle_pkg.sv
// Shared types, widths and register codes of the line filter with edge clamp.
package fle_pkg;

    localparam int OUT_W     = 43;
    localparam int IN_W      = 16;
    localparam int COEF_W    = 16;
    localparam int NUM_COEF  = 8;
    localparam int CFG_W     = 64;
    localparam int REG_IDX_W = 3;
    localparam int TAP_W     = 4;
    localparam int K_W       = 3;
    localparam int FILL_W    = 4;
    localparam int Q_DEPTH   = 4;
    // results one input word may release before the next one is parked
    localparam int RES_LIMIT = 4;

    localparam logic [REG_IDX_W-1:0] REG_COEFFS_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEFFS_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_SHIFT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_ENABLE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_VALUE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE   = 3'd6;

    localparam logic signed [OUT_W-1:0] MAX_VALUE_RST = 43'sd16776960;

    typedef struct packed {
        logic [IN_W-1:0] sample;
        logic            line_end;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    out_line_end;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0]        coeffs_low;
        logic [CFG_W-1:0]        coeffs_high;
        logic [TAP_W-1:0]        tap_count;
        logic [3:0]              scale_shift;
        logic                    clip_enable;
        logic signed [OUT_W-1:0] min_value;
        logic signed [OUT_W-1:0] max_value;
    } cfg_t;

    // One job for the arithmetic side: where to centre, how much of the line is there
    typedef struct packed {
        logic              release_parked;
        logic              calc;
        logic              park;
        logic              is_last;
        logic [K_W-1:0]    k;
        logic [FILL_W-1:0] fill;
    } job_ctrl_t;

    function automatic logic [TAP_W-1:0] taps_used(logic [TAP_W-1:0] tap_count,
                                                   logic [TAP_W-1:0] max_taps);
        logic [TAP_W-1:0] t;
        t = tap_count;
        if (t == '0) t = 4'd1;
        if (t > max_taps) t = max_taps;
        return t;
    endfunction

endpackage

>>> rtl/fle_queue.sv
// Short job queue between the front and the arithmetic back end.
module fle_queue import fle_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    logic [DATA_W-1:0] mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full    = (count_reg == (PTR_W+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            if (pop)  rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            if (push && !pop)      count_reg <= (PTR_W+1)'(count_reg + 1'b1);
            else if (!push && pop) count_reg <= (PTR_W+1)'(count_reg - 1'b1);
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("job pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("job popped from an empty queue");

endmodule

>>> rtl/fle_front.sv
// Front end: takes sample words, keeps the window and line count, issues filter jobs.
module fle_front import fle_pkg::*; #(
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cfg_t                                  cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  in_word_t                              s_payload,
    output logic                                  job_push,
    output job_ctrl_t                             job_ctrl,
    output logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]  job_win,
    input  logic                                  q_full
);

    logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_reg, win_next;
    logic [FILL_W-1:0] fill_reg;
    logic              flush_reg;
    logic [K_W-1:0]    flush_k_reg;
    logic [FILL_W-1:0] flush_n_reg;
    logic [K_W-1:0]    flush_idx_reg;
    logic              park_pend_reg;

    logic [TAP_W-1:0] taps;
    logic [K_W-1:0]   tm1, lag, kmax;
    logic             accept;

    assign taps    = taps_used(cfg.tap_count, TAP_W'(MAX_TAPS));
    assign tm1     = K_W'(taps - 4'd1);
    assign lag     = K_W'(tm1 - (tm1 >> 1));
    assign kmax    = (fill_reg < {1'b0, lag}) ? fill_reg[K_W-1:0] : lag;
    assign s_ready = !flush_reg && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        win_next[0] = s_payload.sample[SAMPLE_BITS-1:0];
        for (int j = 1; j < MAX_TAPS; j++) begin
            win_next[j] = win_reg[j-1];
        end
    end

    always_comb begin
        job_push = 1'b0;
        job_ctrl = '0;
        job_win  = win_reg;
        if (flush_reg) begin
            // drain the rest of the line end, newest position last
            job_ctrl.k       = flush_k_reg;
            job_ctrl.fill    = flush_n_reg;
            job_ctrl.calc    = 1'b1;
            job_ctrl.is_last = (flush_k_reg == '0);
            job_ctrl.park    = (flush_idx_reg == K_W'(RES_LIMIT));
            job_push         = !q_full;
        end else if (accept) begin
            job_win                 = win_next;
            job_ctrl.fill           = fill_reg;
            job_ctrl.release_parked = park_pend_reg;
            if (s_payload.line_end) begin
                job_ctrl.k       = kmax;
                job_ctrl.calc    = 1'b1;
                job_ctrl.is_last = (kmax == '0);
                job_push         = 1'b1;
            end else begin
                job_ctrl.k    = lag;
                job_ctrl.calc = (fill_reg >= {1'b0, lag});
                job_push      = job_ctrl.calc || park_pend_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= '0;
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            flush_k_reg   <= '0;
            flush_n_reg   <= '0;
            flush_idx_reg <= '0;
            park_pend_reg <= 1'b0;
        end else if (flush_reg) begin
            if (!q_full) begin
                flush_k_reg   <= K_W'(flush_k_reg - 1'b1);
                flush_idx_reg <= K_W'(flush_idx_reg + 1'b1);
                if (flush_k_reg == '0) begin
                    flush_reg <= 1'b0;
                end
                if (flush_idx_reg == K_W'(RES_LIMIT)) begin
                    park_pend_reg <= 1'b1;
                end
            end
        end else if (accept) begin
            win_reg       <= win_next;
            park_pend_reg <= 1'b0;
            if (s_payload.line_end) begin
                fill_reg <= '0;
                if (kmax != '0) begin
                    flush_reg     <= 1'b1;
                    flush_k_reg   <= K_W'(kmax - 1'b1);
                    flush_n_reg   <= fill_reg;
                    flush_idx_reg <= K_W'(1);
                end
            end else if (fill_reg != '1) begin
                fill_reg <= FILL_W'(fill_reg + 1'b1);
            end
        end
    end

    a_flush_no_park: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> !park_pend_reg) else $error("parked result pending during a flush");

endmodule

>>> rtl/fle_back.sv
// Back end: tap products, sum, scaling with saturation, clipping and the result register.
module fle_back import fle_pkg::*; #(
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cfg_t                                  cfg,
    input  logic                                  q_empty,
    input  job_ctrl_t                             q_ctrl,
    input  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]  q_win,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output out_word_t                             m_payload
);

    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 3;
    localparam int EXT_A  = SUM_W + FRAC_BITS + 1;
    localparam int EXT_W  = (EXT_A > OUT_W + 1) ? EXT_A : OUT_W + 1;
    localparam int SH_W   = 6;

    localparam logic signed [EXT_W-1:0] SAT_HI =
        $signed({{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] SAT_LO =
        $signed({{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});

    logic en;

    // stage 1: products
    logic                     s1_valid_reg;
    job_ctrl_t                s1_ctrl_reg;
    logic signed [PROD_W-1:0] prod_next [MAX_TAPS];
    logic signed [PROD_W-1:0] prod_reg  [MAX_TAPS];
    // stage 2: sum
    logic                     s2_valid_reg;
    job_ctrl_t                s2_ctrl_reg;
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    // stage 3: scaled and saturated
    logic                     s3_valid_reg;
    job_ctrl_t                s3_ctrl_reg;
    logic signed [OUT_W-1:0]  scaled_next, scaled_reg;
    // result register and parked result
    logic                     out_valid_reg;
    job_ctrl_t                out_ctrl_reg;
    logic signed [OUT_W-1:0]  clip_next, out_val_reg;
    logic                     parked_valid_reg;
    logic signed [OUT_W-1:0]  parked_val_reg;

    logic [TAP_W-1:0]         taps;
    logic [K_W-1:0]           off;
    logic [2*CFG_W-1:0]       coef_all;
    logic                     show_parked, show_value, consume;

    assign taps     = taps_used(cfg.tap_count, TAP_W'(MAX_TAPS));
    assign off      = K_W'(K_W'(taps - 4'd1) >> 1);
    assign coef_all = {cfg.coeffs_high, cfg.coeffs_low};

    always_comb begin
        int                     d;
        logic [SAMPLE_BITS-1:0] smp;
        logic [COEF_W-1:0]      coef;
        for (int i = 0; i < MAX_TAPS; i++) begin
            // clamp the tap position to the samples of this line
            d = int'(q_ctrl.k) + int'(off) - i;
            if (d < 0) d = 0;
            if (d > int'(q_ctrl.fill)) d = int'(q_ctrl.fill);
            if (d > MAX_TAPS - 1) d = MAX_TAPS - 1;
            smp = '0;
            for (int j = 0; j < MAX_TAPS; j++) begin
                if (d == j) smp = q_win[j];
            end
            coef = coef_all[COEF_W*i +: COEF_W];
            if (i < int'(taps)) begin
                prod_next[i] = $signed(coef) * $signed({1'b0, smp});
            end else begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            sum_next = SUM_W'(sum_next + SUM_W'(prod_reg[i]));
        end
    end

    always_comb begin
        logic signed [EXT_W-1:0] ext, v;
        logic [SH_W-1:0]         r;
        ext = EXT_W'(sum_reg);
        r   = '0;
        if ({2'b00, cfg.scale_shift} <= SH_W'(FRAC_BITS)) begin
            v = ext <<< (SH_W'(FRAC_BITS) - {2'b00, cfg.scale_shift});
        end else begin
            // round to nearest, ties upwards
            r = {2'b00, cfg.scale_shift} - SH_W'(FRAC_BITS);
            v = (ext + $signed(EXT_W'(1) << (r - 1'b1))) >>> r;
        end
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        scaled_next = OUT_W'(v);
    end

    always_comb begin
        clip_next = scaled_reg;
        if (cfg.clip_enable) begin
            if (clip_next > cfg.max_value) clip_next = cfg.max_value;
            if (clip_next < cfg.min_value) clip_next = cfg.min_value;
        end
    end

    // output: a parked result goes out ahead of the word that releases it
    assign show_parked = out_valid_reg && out_ctrl_reg.release_parked && parked_valid_reg;
    assign show_value  = out_valid_reg && !show_parked && out_ctrl_reg.calc
                         && !out_ctrl_reg.park;
    assign consume     = out_valid_reg && !show_parked
                         && (!out_ctrl_reg.calc || out_ctrl_reg.park || m_ready);
    assign en          = !out_valid_reg || consume;
    assign q_pop       = en && !q_empty;

    assign m_valid                = show_parked || show_value;
    assign m_payload.filtered     = show_parked ? parked_val_reg : out_val_reg;
    assign m_payload.out_line_end = show_parked ? 1'b1 : out_ctrl_reg.is_last;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctrl_reg  <= q_ctrl;
            prod_reg     <= prod_next;
            s2_ctrl_reg  <= s1_ctrl_reg;
            sum_reg      <= sum_next;
            s3_ctrl_reg  <= s2_ctrl_reg;
            scaled_reg   <= scaled_next;
            out_ctrl_reg <= s3_ctrl_reg;
            out_val_reg  <= clip_next;
        end
        if (out_valid_reg && !show_parked && out_ctrl_reg.calc && out_ctrl_reg.park) begin
            parked_val_reg <= out_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            parked_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                s1_valid_reg  <= q_pop;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (show_parked && m_ready) begin
                parked_valid_reg <= 1'b0;
            end else if (out_valid_reg && !show_parked && out_ctrl_reg.calc
                         && out_ctrl_reg.park) begin
                parked_valid_reg <= 1'b1;
            end
        end
    end

    a_park_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_ctrl_reg.calc && out_ctrl_reg.park) |-> !parked_valid_reg)
        else $error("parked result overwritten");
    a_park_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (parked_valid_reg && !show_parked) |=> parked_valid_reg)
        else $error("parked result dropped without being sent");

endmodule

>>> rtl/fir_line_filter_edge_clamp.sv
// Line filter with edge clamp: register file and the front, queue and back end.
// Path: the job of an accepted input word passes the queue, product, sum, scale and
// clip registers before its result word is valid, while the output is not stalled.
// Throughput: one sample word per cycle unless the queue is full; a line end word holds
// input while flushing up to four positions; a fifth result waits for the next word.
// Sync reset (aresetn low) clears window, count, queue, pipeline and presets registers.
module fir_line_filter_edge_clamp import fle_pkg::*; #(
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_payload,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int WIN_W = MAX_TAPS * SAMPLE_BITS;
    localparam int JOB_W = $bits(job_ctrl_t) + WIN_W;

    cfg_t cfg_reg;

    job_ctrl_t                            job_ctrl, q_ctrl;
    logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] job_win, q_win;
    logic                                 job_push, q_full, q_empty, q_pop;
    logic [JOB_W-1:0]                     q_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coeffs_low  <= '0;
            cfg_reg.coeffs_high <= '0;
            cfg_reg.tap_count   <= 4'd1;
            cfg_reg.scale_shift <= '0;
            cfg_reg.clip_enable <= 1'b0;
            cfg_reg.min_value   <= '0;
            cfg_reg.max_value   <= MAX_VALUE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COEFFS_LOW:  cfg_reg.coeffs_low  <= cfg_wdata;
                REG_COEFFS_HIGH: cfg_reg.coeffs_high <= cfg_wdata;
                REG_TAP_COUNT:   cfg_reg.tap_count   <= cfg_wdata[TAP_W-1:0];
                REG_SCALE_SHIFT: cfg_reg.scale_shift <= cfg_wdata[3:0];
                REG_CLIP_ENABLE: cfg_reg.clip_enable <= cfg_wdata[0];
                REG_MIN_VALUE:   cfg_reg.min_value   <= $signed(cfg_wdata[OUT_W-1:0]);
                REG_MAX_VALUE:   cfg_reg.max_value   <= $signed(cfg_wdata[OUT_W-1:0]);
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    fle_front #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .job_push  (job_push),
        .job_ctrl  (job_ctrl),
        .job_win   (job_win),
        .q_full    (q_full)
    );

    fle_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .wr_data ({job_ctrl, job_win}),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign {q_ctrl, q_win} = q_rd_data;

    fle_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_ctrl    (q_ctrl),
        .q_win     (q_win),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
